[design/rc4_stream_cipher_top_macros.svh]
// Assertion helpers for the checker of this block.
`ifndef RC4_STREAM_CIPHER_TOP_MACROS_SVH
`define RC4_STREAM_CIPHER_TOP_MACROS_SVH

// Check that cons holds on the cycle after ante.
`define RC4_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rc4 check failed on the following cycle");

// Check that cons holds in the same cycle as ante.
`define RC4_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rc4 check failed in the same cycle");

`endif

[design/rc4_pkg.sv]
package rc4_pkg;

	// Request type codes
	localparam logic REQ_KEY  = 1'b0;
	localparam logic REQ_DATA = 1'b1;

	typedef struct packed {
		logic       req_type;
		logic [7:0] byte_value;
		logic       last;
	} rc4_req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic       keyed;
	} rc4_rsp_t;

endpackage

[design/rc4_stream_cipher_top.sv]
// A key byte is stored while idle. The last key byte starts the key schedule, a fill of
// the permutation and then states KA to KE for each entry, during which req_stall is high.
// A keyed data byte passes states D0 to D4 and PUT, a sequence set by the single-port
// permutation RAM; an unkeyed byte goes straight to PUT. Either is loaded into the output
// register before a new byte is taken. A result held by rsp_stall holds the sequencer and
// the input. Reset clears control state, counters and the output valid; neither RAM is cleared.
module rc4_stream_cipher_top #(
	parameter int MAX_KEY_BYTES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  rc4_pkg::rc4_req_t req_data,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rc4_pkg::rc4_rsp_t rsp_data
);
	import rc4_pkg::*;

	localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam int KLEN_W = $clog2(MAX_KEY_BYTES + 1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_FILL = 4'd1;
	localparam logic [3:0] ST_KA   = 4'd2;
	localparam logic [3:0] ST_KB   = 4'd3;
	localparam logic [3:0] ST_KC   = 4'd4;
	localparam logic [3:0] ST_KD   = 4'd5;
	localparam logic [3:0] ST_KE   = 4'd6;
	localparam logic [3:0] ST_D0   = 4'd7;
	localparam logic [3:0] ST_D1   = 4'd8;
	localparam logic [3:0] ST_D2   = 4'd9;
	localparam logic [3:0] ST_D3   = 4'd10;
	localparam logic [3:0] ST_D4   = 4'd11;
	localparam logic [3:0] ST_PUT  = 4'd12;

	logic [3:0]        state_q;
	logic [7:0]        i_q;
	logic [7:0]        j_q;
	logic [7:0]        n_q;
	logic [7:0]        sa_q;
	logic [7:0]        sj_q;
	logic [7:0]        t_q;
	logic [7:0]        k_q;
	logic [7:0]        byte_q;
	logic              last_q;
	logic              key_ready_q;
	logic [KLEN_W-1:0] key_len_q;
	logic [KIDX_W-1:0] kidx_q;
	logic              out_valid_q;
	rc4_rsp_t          out_data_q;

	// Permutation RAM, one port
	logic [7:0] perm_mem [256];
	logic [7:0] p_addr;
	logic [7:0] p_wdata;
	logic [7:0] p_rd;
	logic       p_we;
	logic       p_re;

	// Key RAM, one port
	logic [7:0]        key_mem [MAX_KEY_BYTES];
	logic [KIDX_W-1:0] k_addr;
	logic [7:0]        k_rd;
	logic              k_we;
	logic              k_re;

	// Shared byte adder
	logic [7:0] add_a;
	logic [7:0] add_b;
	logic [7:0] sum;

	logic              accept;
	logic              key_room;
	logic [KLEN_W-1:0] klen_m1;
	logic [KIDX_W-1:0] klen_last;
	logic              out_load;
	rc4_rsp_t          result;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign key_room  = (key_len_q < KLEN_W'(MAX_KEY_BYTES));
	assign klen_m1   = (key_len_q == '0) ? '0 : key_len_q - KLEN_W'(1);
	assign klen_last = klen_m1[KIDX_W-1:0];

	// Select operands of the shared adder
	always_comb begin
		unique case (state_q) inside
			ST_D0: begin
				add_a = i_q;
				add_b = 8'd1;
			end
			ST_D1, ST_KB: begin
				add_a = j_q;
				add_b = p_rd;
			end
			ST_D3: begin
				add_a = sa_q;
				add_b = sj_q;
			end
			ST_KC: begin
				add_a = j_q;
				add_b = k_q;
			end
			default: begin
				add_a = 8'd0;
				add_b = 8'd0;
			end
		endcase
	end

	// Wrap the sum at eight bits
	assign sum = add_a + add_b;

	// Drive the permutation port
	always_comb begin
		p_we    = 1'b0;
		p_re    = 1'b0;
		p_addr  = n_q;
		p_wdata = n_q;
		unique case (state_q) inside
			ST_FILL: p_we = 1'b1;
			ST_KA: p_re = 1'b1;
			ST_KC, ST_D0, ST_D1: begin
				p_re   = 1'b1;
				p_addr = sum;
			end
			ST_KD: begin
				p_we    = 1'b1;
				p_wdata = p_rd;
			end
			ST_KE: begin
				p_we    = 1'b1;
				p_addr  = j_q;
				p_wdata = sa_q;
			end
			ST_D2: begin
				p_we    = 1'b1;
				p_addr  = i_q;
				p_wdata = p_rd;
			end
			ST_D3: begin
				p_we    = 1'b1;
				p_addr  = j_q;
				p_wdata = sa_q;
			end
			ST_D4: begin
				p_re   = 1'b1;
				p_addr = t_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (p_we) begin
			perm_mem[p_addr] <= p_wdata;
		end else if (p_re) begin
			p_rd <= perm_mem[p_addr];
		end
	end

	// Drive the key port: store on a key transaction, read during the schedule
	assign k_we   = accept && (req_data.req_type == REQ_KEY) && key_room;
	assign k_re   = (state_q == ST_KA);
	assign k_addr = k_we ? key_len_q[KIDX_W-1:0] : kidx_q;

	always_ff @(posedge clk) begin
		if (k_we) begin
			key_mem[k_addr] <= req_data.byte_value;
		end else if (k_re) begin
			k_rd <= key_mem[k_addr];
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			n_q         <= '0;
			kidx_q      <= '0;
			key_len_q   <= '0;
			key_ready_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (req_data.req_type == REQ_KEY)) begin
						if (key_room) begin
							key_len_q <= key_len_q + KLEN_W'(1);
						end
						if (req_data.last) begin
							n_q     <= '0;
							j_q     <= '0;
							kidx_q  <= '0;
							state_q <= ST_FILL;
						end
					end else if (accept) begin
						state_q <= key_ready_q ? ST_D0 : ST_PUT;
					end
				end
				ST_FILL: begin
					n_q <= n_q + 8'd1;
					if (n_q == 8'hFF) begin
						state_q <= ST_KA;
					end
				end
				ST_KA: state_q <= ST_KB;
				ST_KB: begin
					j_q     <= sum;
					state_q <= ST_KC;
				end
				ST_KC: begin
					j_q     <= sum;
					state_q <= ST_KD;
				end
				ST_KD: state_q <= ST_KE;
				ST_KE: begin
					kidx_q <= (kidx_q == klen_last) ? '0 : kidx_q + KIDX_W'(1);
					n_q    <= n_q + 8'd1;
					if (n_q == 8'hFF) begin
						i_q         <= '0;
						j_q         <= '0;
						key_len_q   <= '0;
						key_ready_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						state_q <= ST_KA;
					end
				end
				ST_D0: begin
					i_q     <= sum;
					state_q <= ST_D1;
				end
				ST_D1: begin
					j_q     <= sum;
					state_q <= ST_D2;
				end
				ST_D2: state_q <= ST_D3;
				ST_D3: state_q <= ST_D4;
				ST_D4: state_q <= ST_PUT;
				ST_PUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the item and the working bytes of the swap
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= req_data.byte_value;
			last_q <= req_data.last;
		end
		if (state_q == ST_KB) begin
			sa_q <= p_rd;
			k_q  <= k_rd;
		end
		if (state_q == ST_D1) begin
			sa_q <= p_rd;
		end
		if (state_q == ST_D2) begin
			sj_q <= p_rd;
		end
		if (state_q == ST_D3) begin
			t_q <= sum;
		end
	end

	// Form the result from the keystream byte read last
	always_comb begin
		result.out_byte = key_ready_q ? (byte_q ^ p_rd) : byte_q;
		result.out_last = last_q;
		result.keyed    = key_ready_q;
	end

	// Output register: load when empty or being taken, drop after the transaction
	assign out_load = (state_q == ST_PUT) && (!out_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= result;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_data_q;

endmodule

[design/rc4_checker.sv]
`include "rc4_stream_cipher_top_macros.svh"

module rc4_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input rc4_pkg::rc4_req_t req_data,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input rc4_pkg::rc4_rsp_t rsp_data
);
	import rc4_pkg::*;

	// A stalled result holds its value
	`RC4_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

	// A result leaves only through a transaction
	`RC4_ASSERT_NOW(a_rsp_drop, $fell(rsp_valid), $past(!rsp_stall))

	// No result appears on the cycle after any request transaction
	`RC4_ASSERT_NEXT(a_no_early_rsp, req_valid && !req_stall && !rsp_valid, !rsp_valid)

	// A data transaction keeps the block busy for the next cycle
	`RC4_ASSERT_NEXT(a_data_busy, req_valid && !req_stall && (req_data.req_type == REQ_DATA),
		req_stall)

endmodule

bind rc4_stream_cipher_top rc4_checker u_rc4_checker (.*);

[bench/rc4_stream_cipher_checker.sv]
`timescale 1ns / 100ps

module rc4_stream_cipher_checker #(
	parameter int MAX_KEY_BYTES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_stall,
	input  rc4_pkg::rc4_req_t req_data,
	input  logic              rsp_valid,
	input  logic              rsp_stall,
	input  rc4_pkg::rc4_rsp_t rsp_data,
	output int unsigned       error_count,
	output int unsigned       outstanding
);
	import rc4_pkg::*;

	// Own copy of the cipher state
	logic [7:0] sbox [256];
	logic [7:0] key_bytes [256];
	logic [8:0] key_len;
	logic [7:0] idx_i;
	logic [7:0] idx_j;
	logic       key_loaded;
	rc4_rsp_t   cipher_out_q [$];

	// Rebuild the permutation from the collected key, repeating it over its length
	task automatic key_schedule();
		int unsigned len;
		logic [7:0]  j;
		logic [7:0]  tmp;
		len = (key_len == 9'd0) ? 1 : key_len;
		if (len > 256)
			len = 256;
		for (int n = 0; n < 256; n++)
			sbox[n] = 8'(n);
		j = 8'd0;
		for (int n = 0; n < 256; n++) begin
			j       = j + sbox[n] + key_bytes[n % len];
			tmp     = sbox[n];
			sbox[n] = sbox[j];
			sbox[j] = tmp;
		end
		idx_i      = 8'd0;
		idx_j      = 8'd0;
		key_len    = 9'd0;
		key_loaded = 1'b1;
	endtask

	// Absorb one request transaction and queue the byte it should produce
	task automatic keystream_step(input rc4_req_t req);
		rc4_rsp_t   rsp;
		logic [7:0] tmp;
		logic [7:0] ks_idx;
		if (req.req_type == REQ_KEY) begin
			// drop key bytes past the store
			if (key_len < MAX_KEY_BYTES && key_len < 9'd256) begin
				key_bytes[key_len[7:0]] = req.byte_value;
				key_len = key_len + 9'd1;
			end
			if (req.last)
				key_schedule();
		end else begin
			if (key_loaded) begin
				idx_i       = idx_i + 8'd1;
				idx_j       = idx_j + sbox[idx_i];
				tmp         = sbox[idx_i];
				sbox[idx_i] = sbox[idx_j];
				sbox[idx_j] = tmp;
				ks_idx      = sbox[idx_i] + sbox[idx_j];
				rsp.out_byte = req.byte_value ^ sbox[ks_idx];
				rsp.keyed    = 1'b1;
			end else begin
				// no key yet: pass the byte through untouched
				rsp.out_byte = req.byte_value;
				rsp.keyed    = 1'b0;
			end
			rsp.out_last = req.last;
			cipher_out_q.push_back(rsp);
		end
	endtask

	// Compare one response transaction with the oldest queued byte
	task automatic check_response(input rc4_rsp_t got);
		rc4_rsp_t want;
		if (cipher_out_q.size() == 0) begin
			$error("rsp: unexpected transaction, out_byte %02h out_last %0b keyed %0b",
				got.out_byte, got.out_last, got.keyed);
			error_count++;
		end else begin
			want = cipher_out_q.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
				error_count++;
			end
			if (got.out_last !== want.out_last) begin
				$error("out_last: expected %0b, got %0b", want.out_last, got.out_last);
				error_count++;
			end
			if (got.keyed !== want.keyed) begin
				$error("keyed: expected %0b, got %0b", want.keyed, got.keyed);
				error_count++;
			end
		end
	endtask

	// Watch both channels on every edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len     = 9'd0;
			idx_i       = 8'd0;
			idx_j       = 8'd0;
			key_loaded  = 1'b0;
			error_count = 0;
			cipher_out_q.delete();
		end else begin
			if (rsp_valid && !rsp_stall)
				check_response(rsp_data);
			if (req_valid && !req_stall)
				keystream_step(req_data);
		end
		outstanding = cipher_out_q.size();
	end

endmodule

[bench/rc4_stream_cipher_top_tb.sv]
`timescale 1ns / 100ps

module rc4_stream_cipher_top_tb;
	import rc4_pkg::*;

	localparam int MAX_KEY_BYTES = 256;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 2000;
	localparam int LONG_HOLD     = 2000;
	localparam int RANDOM_ITEMS  = 165;
	localparam int QUIET_FROM    = 135;
	localparam int HOLD_FROM     = 40;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	rc4_req_t    req_data  = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rc4_rsp_t    rsp_data;

	int unsigned error_count;
	int unsigned outstanding;
	int unsigned cycle_count = 0;
	int unsigned sent_items  = 0;
	int unsigned gap_pct     = 0;
	bit          quiet       = 1'b0;
	bit          hold_go     = 1'b0;
	bit          hold_done   = 1'b0;

	rc4_stream_cipher_top #(
		.MAX_KEY_BYTES(MAX_KEY_BYTES)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data (rsp_data)
	);

	rc4_stream_cipher_checker #(
		.MAX_KEY_BYTES(MAX_KEY_BYTES)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_data   (req_data),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp_data   (rsp_data),
		.error_count(error_count),
		.outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abandon a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("rc4_stream_cipher_top_tb: done, errors");
			$finish;
		end
	end

	// Idle share for the next stretch, often none
	function automatic int unsigned pick_idle_pct();
		case ($urandom_range(0, 3)) inside
			0, 1:    return 0;
			2:       return 10;
			default: return 35;
		endcase
	endfunction

	// Offer one request transaction and hold it until accepted
	task automatic send_item(input logic kind, input logic [7:0] value, input logic last);
		rc4_req_t item;
		item.req_type   = kind;
		item.byte_value = value;
		item.last       = last;
		if (!quiet && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= item;
		do begin
			@(posedge clk);
		end while (req_stall);
		sent_items++;
	endtask

	// Load a key of random bytes, optionally slipping data bytes in between
	task automatic send_key(input int unsigned len, input int unsigned interleave_pct);
		for (int unsigned k = 0; k < len; k++) begin
			if (interleave_pct != 0 && $urandom_range(0, 99) < interleave_pct)
				send_item(REQ_DATA, 8'($urandom), 1'($urandom));
			send_item(REQ_KEY, 8'($urandom), k == len - 1);
		end
	endtask

	task automatic send_message(input int unsigned len);
		for (int unsigned k = 0; k < len; k++)
			send_item(REQ_DATA, 8'($urandom), k == len - 1);
	endtask

	// Response side: random stall bursts, plus one long hold-off on request
	initial begin : rsp_side
		int unsigned stall_pct;
		int unsigned phase_left;
		stall_pct  = 0;
		phase_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (phase_left == 0) begin
				stall_pct  = pick_idle_pct();
				phase_left = $urandom_range(50, 300);
			end
			phase_left--;
			if (hold_go && !hold_done) begin
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				rsp_stall <= 1'b0;
				hold_done = 1'b1;
			end else if (!quiet && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		int unsigned base;
		int unsigned pick;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Data before any key passes straight through
		gap_pct = 20;
		send_item(REQ_DATA, 8'h00, 1'b0);
		send_item(REQ_DATA, 8'hff, 1'b1);
		send_item(REQ_DATA, 8'ha5, 1'b0);

		// Single-byte zero key
		send_item(REQ_KEY, 8'h00, 1'b1);
		send_item(REQ_DATA, 8'h00, 1'b0);
		send_item(REQ_DATA, 8'hff, 1'b0);
		send_item(REQ_DATA, 8'h5a, 1'b1);

		// Three-byte key, then data while the next key is being collected
		send_item(REQ_KEY, 8'hff, 1'b0);
		send_item(REQ_KEY, 8'h80, 1'b0);
		send_item(REQ_KEY, 8'h01, 1'b1);
		send_item(REQ_DATA, 8'h3c, 1'b0);
		send_item(REQ_KEY, 8'h12, 1'b0);
		send_item(REQ_DATA, 8'h00, 1'b0);
		send_item(REQ_DATA, 8'hff, 1'b1);
		send_item(REQ_KEY, 8'h34, 1'b1);
		send_item(REQ_DATA, 8'h00, 1'b0);
		send_item(REQ_DATA, 8'hff, 1'b1);

		// Overlong key: the store fills, and the marked byte is dropped
		send_key(260, 0);
		send_message(8);

		// Mostly well-formed keys and messages, some noise
		base = sent_items;
		while (sent_items < base + RANDOM_ITEMS) begin
			if (sent_items >= base + QUIET_FROM)
				quiet = 1'b1;
			gap_pct = pick_idle_pct();
			if (!hold_go && sent_items >= base + HOLD_FROM) begin
				// keep offering while the receiver holds off, so the block backs up
				hold_go = 1'b1;
				gap_pct = 0;
				send_message(40);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 12)
					send_key($urandom_range(1, 16), $urandom_range(0, 1) ? 25 : 0);
				else if (pick < 88)
					send_message($urandom_range(1, 24));
				else
					repeat ($urandom_range(1, 4))
						send_item(1'($urandom), 8'($urandom), 1'($urandom));
			end
		end
		req_valid <= 1'b0;

		// Drain, then allow for a trailing key schedule
		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && outstanding == 0)
			$display("rc4_stream_cipher_top_tb: done, clean");
		else
			$display("rc4_stream_cipher_top_tb: done, errors");
		$finish;
	end

endmodule
